// ----- sv/particle_pool_euler_step_unit_assert.svh -----
// assertion macros for the particle pool block
// expects clk and rst in the scope of the module that uses them
`ifndef PARTICLE_POOL_EULER_STEP_UNIT_ASSERT_SVH
`define PARTICLE_POOL_EULER_STEP_UNIT_ASSERT_SVH

// same-cycle implication
`define PPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ppe_pkg.sv -----
// shared constants, item types and internal bundles of the particle pool block
// no dependencies
package ppe_pkg;

  localparam int POOL_SIZE = 32;
  localparam int SLOT_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  localparam int Q_W       = 24;
  localparam int TIME_W    = 20;
  localparam int RATE_W    = 16;
  localparam int RAND_W    = 12;
  localparam int SCALE_W   = 11;
  localparam int VAR_W     = 16;
  localparam int FACTOR_W  = VAR_W + SCALE_W;
  localparam int IDX_OUT_W = 5;

  localparam int MUL_A_W = Q_W + 1;
  localparam int MUL_B_W = FACTOR_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int SH_RAND   = 8;
  localparam int SH_FACTOR = 16;
  localparam int SH_TIME   = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROT_RATE = CFG_IDX_W'(1);

  localparam logic signed [Q_W-1:0] GRAVITY_RESET  = Q_W'(5120);
  localparam logic [RATE_W-1:0]     ROT_RATE_RESET = RATE_W'(655);

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic ACT_EMIT = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SIZE - 1);

  typedef struct packed {
    logic                      action;
    logic [TIME_W-1:0]         delta_time;
    logic signed [Q_W-1:0]     pos_x;
    logic signed [Q_W-1:0]     pos_y;
    logic signed [Q_W-1:0]     vel_x;
    logic signed [Q_W-1:0]     vel_y;
    logic signed [RAND_W-1:0]  rand_x;
    logic signed [RAND_W-1:0]  rand_y;
    logic [SCALE_W-1:0]        rand_scale;
    logic [VAR_W-1:0]          variation;
    logic [TIME_W-1:0]         life_time;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  slot_index;
    logic                  alive;
    logic signed [Q_W-1:0] out_pos_x;
    logic signed [Q_W-1:0] out_pos_y;
    logic [Q_W-1:0]        out_rotation;
    logic [TIME_W-1:0]     out_life;
    logic                  last_slot;
  } out_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] pos_x;
    logic signed [Q_W-1:0] pos_y;
    logic signed [Q_W-1:0] vel_x;
    logic signed [Q_W-1:0] vel_y;
    logic [Q_W-1:0]        rotation;
    logic [TIME_W-1:0]     life;
  } slot_word_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_word_t        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_op_t;

endpackage

// ----- sv/ppe_channels.sv -----
// valid/ready channel interfaces for command items and slot results
// depends on ppe_pkg
interface ppe_in_if import ppe_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppe_out_if import ppe_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ppe_mul.sv -----
// shared signed multiplier with registered product
// depends on ppe_pkg
module ppe_mul import ppe_pkg::*; (
  input  logic                      clk,
  input  mul_op_t                   op,
  output logic signed [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule

// ----- sv/ppe_slot_mem.sv -----
// particle slot storage: one write and one registered read per cycle
// life reads as zero until the slot is first written; depends on ppe_pkg
module ppe_slot_mem import ppe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  mem_wr_t    wr,
  input  mem_rd_t    rd,
  output slot_word_t rdata
);

  slot_word_t             mem [POOL_SIZE];
  logic [POOL_SIZE-1:0]   valid;
  slot_word_t             rword;
  logic                   rvalid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rword <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rvalid <= valid[rd.addr];
      end
    end
  end

  always_comb begin
    rdata = rword;
    if (!rvalid) begin
      rdata.life = '0;
    end
  end

endmodule

// ----- sv/particle_pool_euler_step_unit.sv -----
// Particle pool with Euler stepping. An emit item (action 0) keeps the sequencer busy
// after acceptance and writes one slot at the ring write pointer; it gives no result.
// A tick item (action 1) walks all POOL_SIZE slots in order and gives one result per
// slot, the last one flagged: a dead slot takes read, check and hand-off, a live slot
// read, check, four products and write-back, and an output stall holds the sequencer
// in hand-off. The next command is taken once the sequencer is back in idle, so a new
// item is not taken before the last one is through. All products go through one
// registered multiplier, and the slots sit in a single-port-pair memory read once per
// slot. Commands are taken only while the sequencer is idle; the result register holds
// the last result meanwhile.
// Configuration: index 0 gravity (signed Q16.8), index 1 rotation rate (Q0.16).
`include "particle_pool_euler_step_unit_assert.svh"

module particle_pool_euler_step_unit import ppe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ppe_in_if.sink                cmd,
  ppe_out_if.source             result
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_E0   = 4'd1;
  localparam logic [3:0] S_E1   = 4'd2;
  localparam logic [3:0] S_E2   = 4'd3;
  localparam logic [3:0] S_E3   = 4'd4;
  localparam logic [3:0] S_E4   = 4'd5;
  localparam logic [3:0] S_E5   = 4'd6;
  localparam logic [3:0] S_T_RD = 4'd7;
  localparam logic [3:0] S_T_G  = 4'd8;
  localparam logic [3:0] S_T_V  = 4'd9;
  localparam logic [3:0] S_T_PX = 4'd10;
  localparam logic [3:0] S_T_PY = 4'd11;
  localparam logic [3:0] S_T_R  = 4'd12;
  localparam logic [3:0] S_T_WB = 4'd13;

  logic [3:0]            state;
  in_item_t              item;
  logic [SLOT_W-1:0]     slot_idx;
  logic [SLOT_W-1:0]     write_slot;
  logic signed [Q_W-1:0] gravity;
  logic [RATE_W-1:0]     rotation_rate;
  logic signed [Q_W-1:0] vx_t;
  logic signed [Q_W-1:0] vy_t;
  logic [FACTOR_W-1:0]   factor;
  slot_word_t            w;
  logic                  slot_live;

  mul_op_t                   mul_op;
  logic signed [MUL_P_W-1:0] prod;
  mem_wr_t                   mem_wr;
  mem_rd_t                   mem_rd;
  slot_word_t                mem_rdata;

  logic signed [MUL_P_W-1:0] shifted;
  logic signed [Q_W-1:0]     addend;
  logic signed [MUL_P_W:0]   sum;
  logic signed [Q_W-1:0]     sat_out;
  logic                      out_load;
  logic                      cmd_accept;

  ppe_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  ppe_slot_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_accept = cmd.valid && cmd.ready;
  assign out_load   = (state == S_T_WB) && (!result.valid || result.ready);

  // operand select for the shared multiplier
  always_comb begin
    mul_op = '0;
    case (state)
      S_E0: begin
        mul_op.a = MUL_A_W'(item.vel_x);
        mul_op.b = MUL_B_W'(item.rand_x);
      end
      S_E1: begin
        mul_op.a = MUL_A_W'(item.vel_y);
        mul_op.b = MUL_B_W'(item.rand_y);
      end
      S_E2: begin
        mul_op.a = MUL_A_W'(item.variation);
        mul_op.b = MUL_B_W'(item.rand_scale);
      end
      S_E3: begin
        // variation * scale straight from the product register
        mul_op.a = MUL_A_W'(vx_t);
        mul_op.b = MUL_B_W'(prod[FACTOR_W-1:0]);
      end
      S_E4: begin
        mul_op.a = MUL_A_W'(vy_t);
        mul_op.b = MUL_B_W'(factor);
      end
      S_T_G: begin
        mul_op.a = MUL_A_W'(gravity);
        mul_op.b = MUL_B_W'(item.delta_time);
      end
      S_T_V: begin
        mul_op.a = MUL_A_W'(w.vel_x);
        mul_op.b = MUL_B_W'(item.delta_time);
      end
      S_T_PX: begin
        mul_op.a = MUL_A_W'(w.vel_y);
        mul_op.b = MUL_B_W'(item.delta_time);
      end
      S_T_PY: begin
        mul_op.a = MUL_A_W'(rotation_rate);
        mul_op.b = MUL_B_W'(item.delta_time);
      end
      default: mul_op = '0;
    endcase
  end

  // floor shift, accumulate and saturate to Q16.8
  always_comb begin
    case (state)
      S_E1, S_E2: shifted = prod >>> SH_RAND;
      S_E4, S_E5: shifted = prod >>> SH_FACTOR;
      default:    shifted = prod >>> SH_TIME;
    endcase
    case (state)
      S_T_V:   addend = w.vel_y;
      S_T_PX:  addend = w.pos_x;
      S_T_PY:  addend = w.pos_y;
      default: addend = '0;
    endcase
    sum = (MUL_P_W+1)'(shifted) + (MUL_P_W+1)'(addend);
    if (sum > (MUL_P_W+1)'(Q_MAX)) begin
      sat_out = Q_MAX;
    end else if (sum < (MUL_P_W+1)'(Q_MIN)) begin
      sat_out = Q_MIN;
    end else begin
      sat_out = sum[Q_W-1:0];
    end
  end

  always_comb begin
    mem_rd.en   = (state == S_T_RD);
    mem_rd.addr = slot_idx;
    mem_wr.en   = (state == S_E5) || (out_load && slot_live);
    if (state == S_E5) begin
      mem_wr.addr          = write_slot;
      mem_wr.data.pos_x    = item.pos_x;
      mem_wr.data.pos_y    = item.pos_y;
      mem_wr.data.vel_x    = vx_t;
      mem_wr.data.vel_y    = sat_out;
      mem_wr.data.rotation = '0;
      mem_wr.data.life     = item.life_time;
    end else begin
      mem_wr.addr = slot_idx;
      mem_wr.data = w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity       <= GRAVITY_RESET;
      rotation_rate <= ROT_RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRAVITY:  gravity       <= cfg_data[Q_W-1:0];
        REG_ROT_RATE: rotation_rate <= cfg_data[RATE_W-1:0];
        default:      ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_idx   <= '0;
      write_slot <= '0;
      slot_live  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            slot_idx <= '0;
            state    <= (cmd.data.action == ACT_EMIT) ? S_E0 : S_T_RD;
          end
        end
        S_E0: state <= S_E1;
        S_E1: state <= S_E2;
        S_E2: state <= S_E3;
        S_E3: state <= S_E4;
        S_E4: state <= S_E5;
        S_E5: begin
          write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
          state      <= S_IDLE;
        end
        S_T_RD: state <= S_T_G;
        S_T_G: begin
          slot_live <= (mem_rdata.life != '0);
          state     <= (mem_rdata.life != '0) ? S_T_V : S_T_WB;
        end
        S_T_V:  state <= S_T_PX;
        S_T_PX: state <= S_T_PY;
        S_T_PY: state <= S_T_R;
        S_T_R:  state <= S_T_WB;
        S_T_WB: begin
          if (out_load) begin
            if (slot_idx == LAST_SLOT) begin
              state <= S_IDLE;
            end else begin
              slot_idx <= slot_idx + 1'b1;
              state    <= S_T_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      item <= cmd.data;
    end
    case (state)
      S_E1: vx_t <= sat_out;
      S_E2: vy_t <= sat_out;
      S_E3: factor <= prod[FACTOR_W-1:0];
      S_E4: vx_t <= sat_out;
      S_T_G: begin
        w.pos_x    <= mem_rdata.pos_x;
        w.pos_y    <= mem_rdata.pos_y;
        w.vel_x    <= mem_rdata.vel_x;
        w.vel_y    <= mem_rdata.vel_y;
        w.rotation <= mem_rdata.rotation;
        w.life     <= (mem_rdata.life > item.delta_time) ?
                      mem_rdata.life - item.delta_time : '0;
      end
      S_T_V:  w.vel_y <= sat_out;
      S_T_PX: w.pos_x <= sat_out;
      S_T_PY: w.pos_y <= sat_out;
      S_T_R:  w.rotation <= w.rotation + prod[SH_TIME +: Q_W];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.data.slot_index   <= IDX_OUT_W'(slot_idx);
      result.data.alive        <= slot_live && (w.life != '0);
      result.data.out_pos_x    <= slot_live ? w.pos_x : '0;
      result.data.out_pos_y    <= slot_live ? w.pos_y : '0;
      result.data.out_rotation <= slot_live ? w.rotation : '0;
      result.data.out_life     <= slot_live ? w.life : '0;
      result.data.last_slot    <= (slot_idx == LAST_SLOT);
    end
  end

  `PPE_ASSERT_NOW(a_mem_wr_state, mem_wr.en, (state == S_E5) || (state == S_T_WB),
    "slot memory written outside emit or write-back")
  `PPE_ASSERT_NEXT(a_emit_moves_ptr, state == S_E5, write_slot != $past(write_slot),
    "emit did not advance the write pointer")
  `PPE_ASSERT_NEXT(a_last_slot_idle, out_load && (slot_idx == LAST_SLOT), state == S_IDLE,
    "tick did not end after the last slot")
  `PPE_ASSERT_NEXT(a_dead_slot_zero, out_load && !slot_live,
    (result.data.out_life == '0) && !result.data.alive,
    "dead slot result not cleared")

endmodule

// ----- bench/particle_pool_euler_step_unit_checker.sv -----
`timescale 1ns / 1ps
// checker for the particle pool euler step unit: watches the command, result and
// register ports, keeps its own copy of the pool and compares every slot report
// depends on ppe_pkg and the ppe channel interfaces
module particle_pool_euler_step_unit_checker import ppe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ppe_in_if                     cmd,
  ppe_out_if                    result,
  output int                    mismatches,
  output int                    outstanding
);

  logic signed [Q_W-1:0] slot_px  [POOL_SIZE];
  logic signed [Q_W-1:0] slot_py  [POOL_SIZE];
  logic signed [Q_W-1:0] slot_vx  [POOL_SIZE];
  logic signed [Q_W-1:0] slot_vy  [POOL_SIZE];
  logic [Q_W-1:0]        slot_rot [POOL_SIZE];
  logic [TIME_W-1:0]     slot_life[POOL_SIZE];
  logic [SLOT_W-1:0]     next_slot;
  logic signed [Q_W-1:0] gravity;
  logic [RATE_W-1:0]     spin_rate;
  out_item_t             due_reports[$];

  function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return Q_W'(v);
  endfunction

  // velocity is scaled twice: by the random factor, then by variation * rand_scale
  task automatic emit_particle(input in_item_t it);
    longint gain;
    longint sx;
    longint sy;
    gain = longint'(it.variation) * longint'(it.rand_scale);
    sx = clamp_q((longint'($signed(it.vel_x)) * longint'($signed(it.rand_x))) >>> SH_RAND);
    sy = clamp_q((longint'($signed(it.vel_y)) * longint'($signed(it.rand_y))) >>> SH_RAND);
    sx = clamp_q((sx * gain) >>> SH_FACTOR);
    sy = clamp_q((sy * gain) >>> SH_FACTOR);
    slot_px[next_slot]   = it.pos_x;
    slot_py[next_slot]   = it.pos_y;
    slot_vx[next_slot]   = Q_W'(sx);
    slot_vy[next_slot]   = Q_W'(sy);
    slot_rot[next_slot]  = '0;
    slot_life[next_slot] = it.life_time;
    next_slot = (int'(next_slot) == POOL_SIZE - 1) ? '0 : next_slot + 1'b1;
  endtask

  task automatic tick_pool(input logic [TIME_W-1:0] dt);
    out_item_t rep;
    longint    d;
    int        i;
    d = longint'(dt);
    for (i = 0; i < POOL_SIZE; i++) begin
      rep = '0;
      rep.slot_index = IDX_OUT_W'(i);
      rep.last_slot  = (i == POOL_SIZE - 1);
      // a dead slot is left alone and reports zero apart from its index and last flag
      if (slot_life[i] != '0) begin
        slot_life[i] = (slot_life[i] > dt) ? slot_life[i] - dt : '0;
        slot_vy[i] = clamp_q(longint'(slot_vy[i]) + ((longint'(gravity) * d) >>> SH_TIME));
        slot_px[i] = clamp_q(longint'(slot_px[i]) + ((longint'(slot_vx[i]) * d) >>> SH_TIME));
        slot_py[i] = clamp_q(longint'(slot_py[i]) + ((longint'(slot_vy[i]) * d) >>> SH_TIME));
        slot_rot[i] = slot_rot[i] + Q_W'((longint'(spin_rate) * d) >>> SH_TIME);
        rep.alive        = (slot_life[i] != '0);
        rep.out_pos_x    = slot_px[i];
        rep.out_pos_y    = slot_py[i];
        rep.out_rotation = slot_rot[i];
        rep.out_life     = slot_life[i];
      end
      due_reports.push_back(rep);
    end
  endtask

  function automatic int field_differs(input int slot, input string name,
                                       input logic [31:0] want, input logic [31:0] got);
    if (got === want) return 0;
    $error("slot %0d %s: expected 0x%0h, got 0x%0h", slot, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        slot_life[i] = '0;
      end
      next_slot = '0;
      gravity = GRAVITY_RESET;
      spin_rate = ROT_RATE_RESET;
      due_reports.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRAVITY) begin
          gravity = $signed(cfg_data[Q_W-1:0]);
        end else if (cfg_index == REG_ROT_RATE) begin
          spin_rate = cfg_data[RATE_W-1:0];
        end
      end
      if (cmd.valid && cmd.ready) begin
        if (cmd.data.action == ACT_TICK) begin
          tick_pool(cmd.data.delta_time);
        end else begin
          emit_particle(cmd.data);
        end
      end
      if (result.valid && result.ready) begin
        got = result.data;
        if (due_reports.size() == 0) begin
          $error("slot report for slot %0d with nothing outstanding", got.slot_index);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          mismatches += field_differs(want.slot_index, "slot_index", want.slot_index,
                                      got.slot_index);
          mismatches += field_differs(want.slot_index, "alive", want.alive, got.alive);
          mismatches += field_differs(want.slot_index, "out_pos_x", want.out_pos_x,
                                      got.out_pos_x);
          mismatches += field_differs(want.slot_index, "out_pos_y", want.out_pos_y,
                                      got.out_pos_y);
          mismatches += field_differs(want.slot_index, "out_rotation", want.out_rotation,
                                      got.out_rotation);
          mismatches += field_differs(want.slot_index, "out_life", want.out_life,
                                      got.out_life);
          mismatches += field_differs(want.slot_index, "last_slot", want.last_slot,
                                      got.last_slot);
        end
      end
    end
    outstanding = due_reports.size();
  end

endmodule

// ----- bench/particle_pool_euler_step_unit_tb.sv -----
`timescale 1ns / 1ps
// testbench top for the particle pool euler step unit: clock, reset, register writes,
// command items and result back-pressure; the checker beside the block does the checking
// depends on ppe_pkg, the ppe channel interfaces and the checker module
module particle_pool_euler_step_unit_tb;
  import ppe_pkg::*;

  localparam int HOLD_OFF    = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 20;
  localparam int SEG_ITEMS   = 50;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    quiet_cycles = 0;
  int                    cmds_sent = 0;
  bit                    steady_tx = 1'b0;

  ppe_in_if  cmd_ch();
  ppe_out_if res_ch();

  particle_pool_euler_step_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .result    (res_ch)
  );

  particle_pool_euler_step_unit_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd_ch),
    .result      (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // ends the run when no item moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t raw_cmd();
    in_item_t it;
    it.action     = 1'($urandom);
    it.delta_time = TIME_W'($urandom);
    it.pos_x      = Q_W'($urandom);
    it.pos_y      = Q_W'($urandom);
    it.vel_x      = Q_W'($urandom);
    it.vel_y      = Q_W'($urandom);
    it.rand_x     = RAND_W'($urandom);
    it.rand_y     = RAND_W'($urandom);
    it.rand_scale = SCALE_W'($urandom);
    it.variation  = VAR_W'($urandom);
    it.life_time  = TIME_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t tick_cmd(input logic [TIME_W-1:0] dt);
    in_item_t it;
    it = raw_cmd();
    it.action = ACT_TICK;
    it.delta_time = dt;
    return it;
  endfunction

  function automatic in_item_t emit_cmd(input logic signed [Q_W-1:0] px, py, vx, vy,
                                        input logic signed [RAND_W-1:0] rx, ry,
                                        input logic [SCALE_W-1:0] sc,
                                        input logic [VAR_W-1:0] vr,
                                        input logic [TIME_W-1:0] lt);
    in_item_t it;
    it = raw_cmd();
    it.action     = ACT_EMIT;
    it.pos_x      = px;
    it.pos_y      = py;
    it.vel_x      = vx;
    it.vel_y      = vy;
    it.rand_x     = rx;
    it.rand_y     = ry;
    it.rand_scale = sc;
    it.variation  = vr;
    it.life_time  = lt;
    return it;
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t it;
    it = raw_cmd();
    if ($urandom_range(0, 9) == 0) begin
      // raw bits everywhere, tick length cut down so the pool is not always wiped
      it.delta_time = it.delta_time >> $urandom_range(0, 12);
      return it;
    end
    if ($urandom_range(0, 9) < 3) begin
      it.action = ACT_TICK;
      it.delta_time = ($urandom_range(0, 15) == 0) ? '0 : TIME_W'($urandom_range(1, 'h2000));
      return it;
    end
    it.action = ACT_EMIT;
    if ($urandom_range(0, 1) == 1) begin
      it.pos_x = Q_W'(int'($urandom_range(0, 131072)) - 65536);
      it.pos_y = Q_W'(int'($urandom_range(0, 131072)) - 65536);
    end
    it.vel_x      = Q_W'(int'($urandom_range(0, 8192)) - 4096);
    it.vel_y      = Q_W'(int'($urandom_range(0, 8192)) - 4096);
    it.rand_x     = RAND_W'(int'($urandom_range(0, 2560)) - 1280);
    it.rand_y     = RAND_W'(int'($urandom_range(0, 2560)) - 1280);
    it.rand_scale = SCALE_W'($urandom_range(256, 1280));
    it.variation  = VAR_W'($urandom_range(0, 512));
    it.life_time  = ($urandom_range(0, 15) == 0) ? '0 : TIME_W'($urandom_range(1, 'h20000));
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_cmd(input in_item_t it);
    int gap;
    if (cmds_sent % 32 == 0) steady_tx = ($urandom_range(0, 2) == 0);
    gap = steady_tx ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= it;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    cmds_sent++;
    @(negedge clk);
  endtask

  // stop offering items until every slot report has come back
  task automatic drain_pool(input int extra);
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_regs(input logic signed [Q_W-1:0] g, input logic [RATE_W-1:0] r);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRAVITY;
    cfg_data  <= CFG_DATA_W'(g);
    @(negedge clk);
    cfg_index <= REG_ROT_RATE;
    cfg_data  <= CFG_DATA_W'(r);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // result side: random stalls, plus long hold-offs in the middle of a tick
  initial begin
    int gap;
    int taken;
    bit steady;
    res_ch.ready = 1'b0;
    taken = 0;
    steady = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (taken % 64 == 0) steady = ($urandom_range(0, 2) == 0);
      if (taken == 600 || taken == 1500) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int seg;
    int k;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values; the first tick sees an all-dead pool
    send_cmd(tick_cmd(20'h01000));
    send_cmd(emit_cmd(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 12'sd1280, -12'sd1280, 11'd1280,
                      16'hFFFF, 20'hFFFFF));
    send_cmd(emit_cmd(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 12'sh800, 12'sh7FF, 11'h7FF,
                      16'hFFFF, 20'h00800));
    // zero lifetime: written but stays dead
    send_cmd(emit_cmd(24'sd256, -24'sd256, 24'sd1024, 24'sd1024, 12'sd256, 12'sd256,
                      11'd256, 16'h0100, 20'h00000));
    send_cmd(emit_cmd(24'sd0, 24'sd0, 24'sd256, 24'sd256, 12'sd256, 12'sd256, 11'd256,
                      16'h0100, 20'h02000));
    send_cmd(emit_cmd(-24'sd5000, 24'sd7000, 24'sd300000, -24'sd300000, -12'sd640,
                      12'sd900, 11'd700, 16'h0000, 20'h10000));
    // small negative products exercise the floor rounding
    send_cmd(emit_cmd(24'sd10, -24'sd10, -24'sd1, -24'sd3, 12'sd1, 12'sd100, 11'd256,
                      16'h0001, 20'h00001));
    send_cmd(tick_cmd(20'h00000));
    send_cmd(tick_cmd(20'h00400));
    send_cmd(tick_cmd(20'h00400));
    send_cmd(tick_cmd(20'hFFFFF));
    send_cmd(tick_cmd(20'h01000));

    drain_pool(SETTLE);
    set_regs(Q_MAX, 16'hFFFF);
    send_cmd(emit_cmd(24'sd0, 24'sd0, 24'sd512, -24'sd512, 12'sd256, 12'sd256, 11'd256,
                      16'h0100, 20'hFFFFF));
    send_cmd(emit_cmd(-24'sd100000, 24'sd100000, -24'sd200, 24'sd200, -12'sd1280,
                      12'sd1280, 11'd1280, 16'h0080, 20'h08000));
    send_cmd(emit_cmd(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 12'sd1280, 12'sd1280, 11'd1280,
                      16'hFFFF, 20'h40000));
    send_cmd(tick_cmd(20'h00FFF));
    send_cmd(tick_cmd(20'hFFFFF));

    drain_pool(SETTLE);
    set_regs(Q_MIN, 16'h0000);
    send_cmd(emit_cmd(24'sd0, 24'sd0, 24'sd256, 24'sd256, 12'sd256, 12'sd256, 11'd256,
                      16'h0100, 20'h04000));
    send_cmd(emit_cmd(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 12'sd1280, 12'sd1280, 11'd1280,
                      16'hFFFF, 20'hFFFFF));
    send_cmd(tick_cmd(20'h01000));
    send_cmd(tick_cmd(20'hFFFFF));

    for (seg = 0; seg < 4; seg++) begin
      drain_pool(SETTLE);
      case (seg)
        0: set_regs(GRAVITY_RESET, ROT_RATE_RESET);
        1: set_regs(Q_W'(int'($urandom_range(0, 20480)) - 10240), RATE_W'($urandom));
        2: set_regs(Q_W'($urandom), RATE_W'($urandom));
        default: set_regs(Q_W'(-int'($urandom_range(1, 2560))),
                          RATE_W'($urandom_range(0, 4095)));
      endcase
      for (k = 0; k < SEG_ITEMS; k++) begin
        if (seg == 1 && k == SEG_ITEMS / 2) drain_pool(0);
        send_cmd(random_cmd());
      end
    end

    drain_pool(SETTLE);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
